[design/color_key_sprite_blit_macros.svh]
// assertion macros for the color key sprite blitter
// no dependencies; included by files that carry concurrent checks
`ifndef COLOR_KEY_SPRITE_BLIT_MACROS_SVH
`define COLOR_KEY_SPRITE_BLIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CKB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CKB_ASSERT_NOW(label, clk, rst, ante, cons)
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/ckb_pkg.sv]
// shared types, constants and helpers for the color key sprite blitter
// no dependencies
package ckb_pkg;

   localparam int SPR_DIM_MAX = 1024;
   localparam int SCR_DIM_MAX = 4096;

   localparam int COUNT_W = 10;
   localparam int SPR_W   = 11;
   localparam int SCR_W   = 13;
   localparam int DEST_W  = 12;
   localparam int POS_W   = 13;
   localparam int PIX_W   = 32;
   localparam int ADDR_W  = 24;
   localparam int PROD_W  = 2 * POS_W;
   localparam int CSR_W   = 13;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_START_COL     = 3'd4,
      CSR_START_ROW     = 3'd5,
      CSR_DEST_X        = 3'd6,
      CSR_DEST_Y        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SCR_W-1:0]   screen_width;
      logic [SCR_W-1:0]   screen_height;
      logic [SPR_W-1:0]   sprite_width;
      logic [SPR_W-1:0]   sprite_height;
      logic [COUNT_W-1:0] start_col;
      logic [COUNT_W-1:0] start_row;
      logic [DEST_W-1:0]  dest_x;
      logic [DEST_W-1:0]  dest_y;
   } cfg_type;

   typedef struct packed {
      logic               draw;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [COUNT_W-1:0] col_next;
      logic [COUNT_W-1:0] row_next;
   } place_type;

   // sprite dimension forced into 1..SPR_DIM_MAX
   function automatic logic [SPR_W-1:0] eff_spr_dim(input logic [SPR_W-1:0] v);
      logic [SPR_W-1:0] r;
      r = v;
      if (v == '0) r = SPR_W'(1);
      else if (v > SPR_W'(SPR_DIM_MAX)) r = SPR_W'(SPR_DIM_MAX);
      return r;
   endfunction

   // screen dimension capped at SCR_DIM_MAX
   function automatic logic [SCR_W-1:0] eff_scr_dim(input logic [SCR_W-1:0] v);
      logic [SCR_W-1:0] r;
      r = v;
      if (v > SCR_W'(SCR_DIM_MAX)) r = SCR_W'(SCR_DIM_MAX);
      return r;
   endfunction

endpackage

[design/ckb_place.sv]
// sprite position tracking, skip and key test, placement and clipping
// depends on ckb_pkg
module ckb_place
   import ckb_pkg::*;
(
   input  cfg_type            cfg,
   input  logic [PIX_W-1:0]   pixel_value,
   input  logic               first_pixel,
   input  logic [COUNT_W-1:0] col_count,
   input  logic [COUNT_W-1:0] row_count,
   input  logic [PIX_W-1:0]   key_color,
   output place_type          place
);

   logic [SPR_W-1:0]   sw;
   logic [SPR_W-1:0]   sh;
   logic [SCR_W-1:0]   scw;
   logic [SCR_W-1:0]   sch;
   logic [COUNT_W-1:0] col;
   logic [COUNT_W-1:0] row;
   logic [COUNT_W-1:0] col_off;
   logic [COUNT_W-1:0] row_off;
   logic [SPR_W-1:0]   col_inc;
   logic [SPR_W-1:0]   row_inc;
   logic               opaque;
   logic               in_window;

   always_comb begin
      sw  = eff_spr_dim(cfg.sprite_width);
      sh  = eff_spr_dim(cfg.sprite_height);
      scw = eff_scr_dim(cfg.screen_width);
      sch = eff_scr_dim(cfg.screen_height);

      // a start flag restarts at (0,0); stale counters after a resize wrap
      col = first_pixel ? '0 : col_count;
      row = first_pixel ? '0 : row_count;
      if ({1'b0, col} >= sw) col = '0;
      if ({1'b0, row} >= sh) row = '0;

      // the start pixel is its own key, so it never draws
      opaque    = !first_pixel && (pixel_value != key_color);
      in_window = (col >= cfg.start_col) && (row >= cfg.start_row);

      col_off = col - cfg.start_col;
      row_off = row - cfg.start_row;
      place.x = {1'b0, cfg.dest_x} + POS_W'(col_off);
      place.y = {1'b0, cfg.dest_y} + POS_W'(row_off);
      place.draw = opaque && in_window && (place.x < scw) && (place.y < sch);

      col_inc = {1'b0, col} + SPR_W'(1);
      row_inc = {1'b0, row} + SPR_W'(1);
      place.col_next = col_inc[COUNT_W-1:0];
      place.row_next = row;
      if (col_inc >= sw) begin
         place.col_next = '0;
         place.row_next = (row_inc >= sh) ? '0 : row_inc[COUNT_W-1:0];
      end
   end

endmodule

[design/color_key_sprite_blit.sv]
// color key sprite blitter: an accepted pixel passes stage 1 and stage 2 before its write;
// one pixel per cycle while rsp_stall is low; transparent and clipped pixels give no write.
// stage 1 registers the placed position, stage 2 the address multiply-add.
// synchronous active-high reset restores the default geometry, clears the key
// and the sprite counters and empties both stages.
// depends on ckb_pkg, ckb_place and color_key_sprite_blit_macros.svh
`include "color_key_sprite_blit_macros.svh"
module color_key_sprite_blit
   import ckb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic               req_first_pixel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_write_address,
   output logic [PIX_W-1:0]   rsp_write_value,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_write_data
);

   cfg_type            cfg_ff;
   place_type          place;
   logic [COUNT_W-1:0] col_count_ff;
   logic [COUNT_W-1:0] row_count_ff;
   logic [PIX_W-1:0]   key_color_ff;
   logic [PIX_W-1:0]   key_color_in;

   logic               s1_valid_ff;
   logic [POS_W-1:0]   s1_x_ff;
   logic [POS_W-1:0]   s1_y_ff;
   logic [PIX_W-1:0]   s1_pixel_ff;

   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [PIX_W-1:0]   value_ff;

   logic               s2_ready;
   logic               s1_ready;
   logic               req_accept;
   logic [SCR_W-1:0]   scw;
   logic [PROD_W-1:0]  addr_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCR_W'(640);
         cfg_ff.screen_height <= SCR_W'(480);
         cfg_ff.sprite_width  <= SPR_W'(32);
         cfg_ff.sprite_height <= SPR_W'(32);
         cfg_ff.start_col     <= '0;
         cfg_ff.start_row     <= '0;
         cfg_ff.dest_x        <= '0;
         cfg_ff.dest_y        <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_write_data;
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_write_data;
            CSR_SPRITE_WIDTH:  cfg_ff.sprite_width  <= csr_write_data[SPR_W-1:0];
            CSR_SPRITE_HEIGHT: cfg_ff.sprite_height <= csr_write_data[SPR_W-1:0];
            CSR_START_COL:     cfg_ff.start_col     <= csr_write_data[COUNT_W-1:0];
            CSR_START_ROW:     cfg_ff.start_row     <= csr_write_data[COUNT_W-1:0];
            CSR_DEST_X:        cfg_ff.dest_x        <= csr_write_data[DEST_W-1:0];
            CSR_DEST_Y:        cfg_ff.dest_y        <= csr_write_data[DEST_W-1:0];
         endcase
      end
   end

   ckb_place u_place (
      .cfg         (cfg_ff),
      .pixel_value (req_pixel_value),
      .first_pixel (req_first_pixel),
      .col_count   (col_count_ff),
      .row_count   (row_count_ff),
      .key_color   (key_color_ff),
      .place       (place)
   );

   assign s2_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign key_color_in = req_first_pixel ? req_pixel_value : key_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         key_color_ff <= '0;
      end else if (req_accept) begin
         col_count_ff <= place.col_next;
         row_count_ff <= place.row_next;
         key_color_ff <= key_color_in;
      end
   end

   // stage 1: only drawn pixels occupy the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept && place.draw;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_accept) begin
         s1_x_ff     <= place.x;
         s1_y_ff     <= place.y;
         s1_pixel_ff <= req_pixel_value;
      end
   end

   // stage 2: row times pitch plus column
   assign scw       = eff_scr_dim(cfg_ff.screen_width);
   assign addr_full = PROD_W'(s1_y_ff) * PROD_W'(scw) + PROD_W'(s1_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         addr_ff  <= addr_full[ADDR_W-1:0];
         value_ff <= s1_pixel_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_value   = value_ff;

   `CKB_ASSERT_NEXT(a_first_never_draws, clock, reset, req_accept && req_first_pixel, !s1_valid_ff)
   `CKB_ASSERT_NEXT(a_first_restarts_col, clock, reset, req_accept && req_first_pixel, col_count_ff == COUNT_W'(0) || col_count_ff == COUNT_W'(1))
   `CKB_ASSERT_NOW(a_stall_needs_full_s1, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)
   `CKB_ASSERT_NEXT(a_drain_empties, clock, reset, rsp_valid_ff && !rsp_stall && !s1_valid_ff, !rsp_valid_ff)

endmodule

[bench/tb_color_key_sprite_blit.sv]
// self-checking bench for color_key_sprite_blit: streams sprite pixels, predicts each
// framebuffer write (key, start offsets, clipping, wrap) and checks every write in order.
// depends on ckb_pkg and the color_key_sprite_blit rtl
module tb_color_key_sprite_blit;
   timeunit 1ns;
   timeprecision 1ps;
   import ckb_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_ITEMS  = 740;

   typedef struct {
      logic [PIX_W-1:0] value;
      logic             first;
   } pixel_item_type;

   typedef struct {
      logic [ADDR_W-1:0] address;
      logic [PIX_W-1:0]  value;
   } fb_write_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pixel_value = '0;
   logic                req_first_pixel = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ADDR_W-1:0]   rsp_write_address;
   logic [PIX_W-1:0]    rsp_write_value;
   logic                csr_write_enable = 1'b0;
   csr_index_type       csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_W-1:0]    csr_write_data = '0;

   pixel_item_type      pixels_to_send[$];
   fb_write_type        expected_writes[$];

   // predictor copy of the geometry and the sprite walk
   cfg_type             geo;
   logic [PIX_W-1:0]    chroma_key;
   logic [COUNT_W-1:0]  spr_col;
   logic [COUNT_W-1:0]  spr_row;

   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  gap_left = 0;
   int                  stall_left = 0;
   bit                  send_calm = 1'b0;
   bit                  recv_calm = 1'b0;
   bit                  holding;
   pixel_item_type      next_item;
   fb_write_type        oldest;

   color_key_sprite_blit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_value   (req_pixel_value),
      .req_first_pixel   (req_first_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // sprite dimension as the block uses it: 1..SPR_DIM_MAX
   function automatic logic [SPR_W-1:0] sprite_span(input logic [SPR_W-1:0] raw);
      if (raw == '0) return SPR_W'(1);
      return (raw > SPR_W'(SPR_DIM_MAX)) ? SPR_W'(SPR_DIM_MAX) : raw;
   endfunction

   task automatic place_pixel(input logic [PIX_W-1:0] pix, input logic first);
      logic [SPR_W-1:0]  spr_w;
      logic [SPR_W-1:0]  spr_h;
      logic [SCR_W-1:0]  scr_w;
      logic [SCR_W-1:0]  scr_h;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [PROD_W-1:0] addr;
      logic [SPR_W-1:0]  col_next;
      logic [SPR_W-1:0]  row_next;
      fb_write_type      wr;
      spr_w = sprite_span(geo.sprite_width);
      spr_h = sprite_span(geo.sprite_height);
      scr_w = (geo.screen_width > SCR_W'(SCR_DIM_MAX)) ? SCR_W'(SCR_DIM_MAX) : geo.screen_width;
      scr_h = (geo.screen_height > SCR_W'(SCR_DIM_MAX)) ? SCR_W'(SCR_DIM_MAX)
                                                        : geo.screen_height;
      if (first) begin
         spr_col = '0;
         spr_row = '0;
         chroma_key = pix;
      end
      // a geometry change can leave the walk outside the sprite
      if ({1'b0, spr_col} >= spr_w) spr_col = '0;
      if ({1'b0, spr_row} >= spr_h) spr_row = '0;
      if (spr_col >= geo.start_col && spr_row >= geo.start_row && pix != chroma_key) begin
         x = POS_W'(geo.dest_x) + POS_W'(spr_col - geo.start_col);
         y = POS_W'(geo.dest_y) + POS_W'(spr_row - geo.start_row);
         if (x < scr_w && y < scr_h) begin
            addr = PROD_W'(x) + PROD_W'(y) * PROD_W'(scr_w);
            wr.address = addr[ADDR_W-1:0];
            wr.value = pix;
            expected_writes.push_back(wr);
         end
      end
      col_next = {1'b0, spr_col} + SPR_W'(1);
      if (col_next >= spr_w) begin
         spr_col = '0;
         row_next = {1'b0, spr_row} + SPR_W'(1);
         spr_row = (row_next >= spr_h) ? '0 : row_next[COUNT_W-1:0];
      end else begin
         spr_col = col_next[COUNT_W-1:0];
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            place_pixel(req_pixel_value, req_first_pixel);
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixels_to_send.size() != 0) begin
               next_item = pixels_to_send.pop_front();
               req_pixel_value <= next_item.value;
               req_first_pixel <= next_item.first;
               holding = 1'b1;
               if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
               gap_left = send_calm ? 0 : $urandom_range(0, 11);
            end
         end
         req_valid <= holding;
      end
   end

   // write monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected write, expected none, got address %h value %h",
                        $time, rsp_write_address, rsp_write_value);
               error_count++;
            end else begin
               oldest = expected_writes.pop_front();
               if (oldest.address !== rsp_write_address) begin
                  $display("%0t: write_address expected %h, got %h",
                           $time, oldest.address, rsp_write_address);
                  error_count++;
               end
               if (oldest.value !== rsp_write_value) begin
                  $display("%0t: write_value expected %h, got %h",
                           $time, oldest.value, rsp_write_value);
                  error_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!recv_calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 11);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic send(input logic [PIX_W-1:0] value, input logic first);
      pixel_item_type item;
      item.value = value;
      item.first = first;
      pixels_to_send.push_back(item);
   endtask

   // block drained: nothing queued, nothing in flight, nothing owed
   task automatic wait_idle();
      @(negedge clock);
      while (pixels_to_send.size() != 0 || req_valid || expected_writes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      logic [CSR_W-1:0] data;
      data = CSR_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_SCREEN_WIDTH:  geo.screen_width = data[SCR_W-1:0];
         CSR_SCREEN_HEIGHT: geo.screen_height = data[SCR_W-1:0];
         CSR_SPRITE_WIDTH:  geo.sprite_width = data[SPR_W-1:0];
         CSR_SPRITE_HEIGHT: geo.sprite_height = data[SPR_W-1:0];
         CSR_START_COL:     geo.start_col = data[COUNT_W-1:0];
         CSR_START_ROW:     geo.start_row = data[COUNT_W-1:0];
         CSR_DEST_X:        geo.dest_x = data[DEST_W-1:0];
         CSR_DEST_Y:        geo.dest_y = data[DEST_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_geometry(input int scr_w, input int scr_h, input int spr_w,
                                 input int spr_h, input int col0, input int row0,
                                 input int dx, input int dy);
      write_reg(CSR_SCREEN_WIDTH, scr_w);
      write_reg(CSR_SCREEN_HEIGHT, scr_h);
      write_reg(CSR_SPRITE_WIDTH, spr_w);
      write_reg(CSR_SPRITE_HEIGHT, spr_h);
      write_reg(CSR_START_COL, col0);
      write_reg(CSR_START_ROW, row0);
      write_reg(CSR_DEST_X, dx);
      write_reg(CSR_DEST_Y, dy);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_geometry();
      int scr[2];
      int spr[2];
      int start[2];
      int dest[2];
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 9))
            0:       scr[i] = 0;
            1:       scr[i] = $urandom_range(SCR_DIM_MAX + 1, 8191);
            2:       scr[i] = $urandom_range(1, SCR_DIM_MAX);
            default: scr[i] = $urandom_range(1, 48);
         endcase
         case ($urandom_range(0, 9))
            0:       spr[i] = 0;
            1:       spr[i] = $urandom_range(11, 24);
            default: spr[i] = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       start[i] = $urandom_range(0, 1023);
            1, 2:    start[i] = $urandom_range(0, spr[i] + 1);
            default: start[i] = $urandom_range(0, 2);
         endcase
         case ($urandom_range(0, 9))
            0:       dest[i] = $urandom_range(0, 4095);
            1:       dest[i] = $urandom_range(4080, 4095);
            default: dest[i] = $urandom_range(0, 40);
         endcase
      end
      write_geometry(scr[0], scr[1], spr[0], spr[1], start[0], start[1], dest[0], dest[1]);
   endtask

   // mostly whole images with a fresh key; some cut short, some run past the end
   // without a new start flag, and a little noise
   task automatic queue_stream(input int n_items, output int pushed);
      int img_len;
      int cut;
      logic [PIX_W-1:0] key;
      pushed = 0;
      while (pushed < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send($urandom, $urandom_range(0, 7) == 0);
            pushed++;
         end else begin
            img_len = sprite_span(geo.sprite_width) * sprite_span(geo.sprite_height);
            case ($urandom_range(0, 7))
               0:       key = '0;
               1:       key = '1;
               default: key = $urandom;
            endcase
            case ($urandom_range(0, 9))
               0:       cut = $urandom_range(1, img_len);
               1:       cut = img_len + $urandom_range(1, img_len);
               default: cut = img_len;
            endcase
            send(key, 1'b1);
            for (int k = 1; k < cut; k++) begin
               case ($urandom_range(0, 7))
                  0, 1:    send(key, 1'b0);
                  2:       send(key ^ (32'd1 << $urandom_range(0, 31)), 1'b0);
                  default: send($urandom, 1'b0);
               endcase
            end
            pushed += cut;
         end
      end
   endtask

   initial begin
      int random_sent;
      int pushed;
      geo = '{screen_width: 640, screen_height: 480, sprite_width: 32, sprite_height: 32,
              start_col: 0, start_row: 0, dest_x: 0, dest_y: 0};
      chroma_key = '0;
      spr_col = '0;
      spr_row = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry; the first pixel is the key and is never drawn
      send(32'hA5A5A5A5, 1'b1);
      send(32'h00000000, 1'b0);
      send(32'hFFFFFFFF, 1'b0);
      send(32'hA5A5A5A5, 1'b0);
      send(32'h80000001, 1'b0);
      wait_idle();

      // zero sprite size clamps to one pixel, oversized screen clamps, top address
      write_geometry(8191, 8191, 0, 0, 0, 0, 4095, 4095);
      send(32'h0000005A, 1'b1);
      send(32'hFFFFFFFF, 1'b0);
      send(32'h00000001, 1'b0);
      send(32'h0000005A, 1'b0);
      wait_idle();

      // zero screen width clips everything
      write_geometry(0, 480, 4, 4, 0, 0, 0, 0);
      send(32'h00000000, 1'b1);
      send(32'h00000007, 1'b0);
      send(32'h00000008, 1'b0);
      wait_idle();

      // start offsets skip the key pixel; only one pixel lands on a 1x1 screen
      write_geometry(1, 1, 4, 2, 1, 1, 0, 0);
      send(32'h00000003, 1'b1);
      for (int i = 1; i < 8; i++) send(32'h10 + i, 1'b0);
      wait_idle();

      // start column equal to the sprite width: nothing is drawn
      write_geometry(640, 480, 4, 4, 4, 0, 0, 0);
      send(32'h00000011, 1'b1);
      send(32'h00000022, 1'b0);
      send(32'h00000033, 1'b0);
      wait_idle();

      // oversized sprite width clamps to the maximum; the walk wraps past it
      write_geometry(SCR_DIM_MAX, 8, 2047, 1, 1000, 0, 3000, 5);
      send(32'h0F0F0F0F, 1'b1);
      for (int i = 1; i < 1040; i++)
         send(($urandom_range(0, 7) == 0) ? 32'h0F0F0F0F : $urandom, 1'b0);
      wait_idle();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // sometimes keep the geometry and just resume the walk
         if ($urandom_range(0, 4) != 0) random_geometry();
         queue_stream($urandom_range(80, 220), pushed);
         random_sent += pushed;
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
